// ===== design/postfix_expression_evaluator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the postfix expression evaluator
// Shared concurrent assertion forms.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// implication checked every clock, off during reset
`define PEE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define PEE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Widths, character codes, error codes, states and the arithmetic request and response types.
// ----------------------------------------------------------------------------
package pee_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int SP_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL = 8'h2A;
	localparam logic [7:0] CH_DIV = 8'h2F;
	localparam logic [7:0] CH_MOD = 8'h25;
	localparam logic [7:0] CH_POW = 8'h5E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_UNDER = 3'd1;
	localparam logic [2:0] ERR_OVER = 3'd2;
	localparam logic [2:0] ERR_DIV0 = 3'd3;
	localparam logic [2:0] ERR_NEGEXP = 3'd4;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_MOD,
		OP_POW
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSHNUM,
		ST_POPA,
		ST_POPB,
		ST_WAITB,
		ST_EXEC,
		ST_PUSHRES,
		ST_FINPUSH,
		ST_FINPOP,
		ST_FINWAIT,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		A_IDLE,
		A_DIV,
		A_POW,
		A_DONE
	} alu_state_t;

	typedef struct packed {
		logic start;
		op_t op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic [31:0] res;
		logic [2:0] err;
	} alu_rsp_t;

endpackage

// ===== design/pee_alu.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator arithmetic unit
// Iterative unit: add/sub and multiply in one step, power by square-and-multiply
// with a multiply pair per step, divide and remainder by restoring shift-subtract.
// ----------------------------------------------------------------------------
module pee_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  pee_pkg::alu_req_t   req,
	output pee_pkg::alu_rsp_t   rsp
);

	pee_pkg::alu_state_t state_q, state_d;
	pee_pkg::op_t op_q;
	logic [31:0] res_q;
	logic [2:0] err_q;
	logic [31:0] base_q;
	logic [31:0] exp_q;
	logic [31:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [5:0] cnt_q;
	logic neg_q_q;
	logic neg_r_q;

	logic [63:0] prod_r;
	logic [63:0] prod_b;
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	logic [31:0] abs_a;
	logic [31:0] abs_b;

	assign prod_r = res_q * base_q;
	assign prod_b = base_q * base_q;
	assign rem_sh = {rem_q[31:0], quo_q[31]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign abs_a = req.a[31] ? (~req.a + 32'd1) : req.a;
	assign abs_b = req.b[31] ? (~req.b + 32'd1) : req.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pee_pkg::A_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pee_pkg::A_IDLE: if (req.start) begin
				case (req.op)
					pee_pkg::OP_DIV, pee_pkg::OP_MOD:
						state_d = (req.a == 32'd0) ? pee_pkg::A_DONE : pee_pkg::A_DIV;
					pee_pkg::OP_POW: state_d = req.a[31] ? pee_pkg::A_DONE : pee_pkg::A_POW;
					default: state_d = pee_pkg::A_DONE;
				endcase
			end
			pee_pkg::A_DIV: if (cnt_q == 6'd31) state_d = pee_pkg::A_DONE;
			pee_pkg::A_POW: if (exp_q == 32'd0) state_d = pee_pkg::A_DONE;
			pee_pkg::A_DONE: state_d = pee_pkg::A_IDLE;
			default: state_d = pee_pkg::A_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pee_pkg::A_IDLE: if (req.start) begin
				op_q <= req.op;
				cnt_q <= 6'd0;
				rem_q <= 33'd0;
				quo_q <= abs_b;
				dvs_q <= abs_a;
				neg_q_q <= req.a[31] ^ req.b[31];
				neg_r_q <= req.b[31];
				base_q <= req.b;
				exp_q <= req.a;
				if ((req.op == pee_pkg::OP_DIV || req.op == pee_pkg::OP_MOD)
						&& req.a == 32'd0) begin
					err_q <= pee_pkg::ERR_DIV0;
				end else if (req.op == pee_pkg::OP_POW && req.a[31]) begin
					err_q <= pee_pkg::ERR_NEGEXP;
				end else begin
					err_q <= pee_pkg::ERR_NONE;
				end
				case (req.op)
					pee_pkg::OP_ADD: res_q <= req.a + req.b;
					pee_pkg::OP_SUB: res_q <= req.b - req.a;
					pee_pkg::OP_MUL: res_q <= 32'(req.a * req.b);
					pee_pkg::OP_POW: res_q <= req.a[31] ? 32'd0 : 32'd1;
					default: res_q <= 32'd0;
				endcase
			end
			pee_pkg::A_DIV: begin
				cnt_q <= cnt_q + 6'd1;
				if (!rem_sub[32]) begin
					rem_q <= rem_sub;
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			pee_pkg::A_POW: if (exp_q != 32'd0) begin
				if (exp_q[0]) res_q <= prod_r[31:0];
				base_q <= prod_b[31:0];
				exp_q <= {1'b0, exp_q[31:1]};
			end
			pee_pkg::A_DONE: if (op_q == pee_pkg::OP_DIV && err_q == pee_pkg::ERR_NONE) begin
				res_q <= neg_q_q ? (~quo_q + 32'd1) : quo_q;
			end else if (op_q == pee_pkg::OP_MOD && err_q == pee_pkg::ERR_NONE) begin
				res_q <= neg_r_q ? (~rem_q[31:0] + 32'd1) : rem_q[31:0];
			end
			default: ;
		endcase
	end

	// result is valid the cycle after A_DONE
	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= (state_q == pee_pkg::A_DONE);
	end

	assign rsp.done = done_q;
	assign rsp.res = res_q;
	assign rsp.err = err_q;

endmodule

// ===== design/postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates a character stream in reverse Polish notation on a value stack.
// ----------------------------------------------------------------------------
// Input s_axis: one ASCII character per request in tdata, tlast marks the
// final character of an expression. Output m_axis: one request per
// expression, tdata = {zero[4:0], status[2:0], value[31:0]}, value in the low bits.
// A digit is accumulated into the pending number; any other character is
// accepted and then pushes a pending number. + - * then go through two stack
// reads from the register-read memory, unit start, the unit's operation and a
// result push. / and % run the 32-step shift-subtract loop of the shared unit;
// ^ runs one step per exponent bit up to its highest set bit, one multiply
// pair per step. Divide by zero and a negative exponent skip the unit's loop.
// The last character goes on to the final pop and the output load;
// m_axis_tvalid rises the cycle after the output load.
// s_axis_tready is low while a character is in work. A result the receiver
// has not taken is held in the output register; the next expression runs on
// and waits at its output step until the register frees.
// Reset clears the stack count, number, error and output valid; stack memory
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_assert.svh"

module postfix_expression_evaluator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // char_code[7:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // value[31:0], status[34:32], zero[39:35]
);

	pee_pkg::state_t state_q, state_d;
	logic [pee_pkg::CNT_W-1:0] cnt_q;
	logic [31:0] acc_q;
	logic innum_q;
	logic [2:0] ferr_q;
	logic [7:0] ch_q;
	logic last_q;
	logic [31:0] a_q;
	logic [31:0] out_val_q;
	logic [2:0] out_st_q;
	logic out_v_q;

	logic [31:0] mem [pee_pkg::STACK_DEPTH];
	logic [31:0] rd_q;

	logic wr_en;
	logic [31:0] wr_data;
	logic rd_en;
	logic [pee_pkg::SP_W-1:0] rd_addr;

	pee_pkg::alu_req_t req;
	pee_pkg::alu_rsp_t rsp;

	logic acc;
	logic is_digit;
	logic is_op;
	logic full;
	logic empty;
	logic out_load;
	pee_pkg::op_t op_sel;

	// pop bookkeeping: a_q takes the read data in the cycle after its read
	logic pa_q;
	logic ua_q, ub_q, uf_q;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign is_digit = s_axis_tdata >= pee_pkg::CH_ZERO && s_axis_tdata <= pee_pkg::CH_NINE;
	assign full = cnt_q == pee_pkg::CNT_W'(pee_pkg::STACK_DEPTH);
	assign empty = cnt_q == '0;
	assign rd_addr = pee_pkg::SP_W'(cnt_q - pee_pkg::CNT_W'(1));
	assign out_load = state_q == pee_pkg::ST_OUT && (!out_v_q || m_axis_tready);

	always_comb begin
		is_op = 1'b1;
		op_sel = pee_pkg::OP_ADD;
		case (ch_q)
			pee_pkg::CH_PLUS: op_sel = pee_pkg::OP_ADD;
			pee_pkg::CH_MINUS: op_sel = pee_pkg::OP_SUB;
			pee_pkg::CH_MUL: op_sel = pee_pkg::OP_MUL;
			pee_pkg::CH_DIV: op_sel = pee_pkg::OP_DIV;
			pee_pkg::CH_MOD: op_sel = pee_pkg::OP_MOD;
			pee_pkg::CH_POW: op_sel = pee_pkg::OP_POW;
			default: is_op = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en && !full) mem[cnt_q[pee_pkg::SP_W-1:0]] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	pee_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pee_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		s_axis_tready = 1'b0;
		wr_en = 1'b0;
		wr_data = acc_q;
		rd_en = 1'b0;
		req = '0;
		req.op = op_sel;
		req.a = a_q;
		req.b = ub_q ? 32'hFFFF_FFFF : rd_q;
		case (state_q)
			pee_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (acc && !is_digit) begin
					state_d = pee_pkg::ST_PUSHNUM;
				end else if (acc && s_axis_tlast) begin
					state_d = pee_pkg::ST_FINPUSH;
				end
			end
			pee_pkg::ST_PUSHNUM: begin
				wr_en = innum_q;
				if (is_op) state_d = pee_pkg::ST_POPA;
				else if (last_q) state_d = pee_pkg::ST_FINPOP;
				else state_d = pee_pkg::ST_IDLE;
			end
			pee_pkg::ST_POPA: begin
				rd_en = !empty;
				state_d = pee_pkg::ST_POPB;
			end
			pee_pkg::ST_POPB: begin
				rd_en = !empty;
				state_d = pee_pkg::ST_WAITB;
			end
			pee_pkg::ST_WAITB: begin
				req.start = 1'b1;
				state_d = pee_pkg::ST_EXEC;
			end
			pee_pkg::ST_EXEC: if (rsp.done) state_d = pee_pkg::ST_PUSHRES;
			pee_pkg::ST_PUSHRES: begin
				wr_en = 1'b1;
				wr_data = rsp.res;
				state_d = last_q ? pee_pkg::ST_FINPOP : pee_pkg::ST_IDLE;
			end
			pee_pkg::ST_FINPUSH: begin
				wr_en = innum_q;
				state_d = pee_pkg::ST_FINPOP;
			end
			pee_pkg::ST_FINPOP: begin
				rd_en = !empty;
				state_d = pee_pkg::ST_FINWAIT;
			end
			pee_pkg::ST_FINWAIT: state_d = pee_pkg::ST_OUT;
			pee_pkg::ST_OUT: if (out_load) state_d = pee_pkg::ST_IDLE;
			default: state_d = pee_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			acc_q <= '0;
			innum_q <= 1'b0;
			ferr_q <= pee_pkg::ERR_NONE;
			out_v_q <= 1'b0;
			pa_q <= 1'b0;
		end else begin
			pa_q <= state_q == pee_pkg::ST_POPA;
			if (out_load) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
			if (acc && is_digit) begin
				acc_q <= 32'(acc_q * 32'd10) + {24'd0, s_axis_tdata - pee_pkg::CH_ZERO};
				innum_q <= 1'b1;
			end
			if (wr_en) begin
				if (full) begin
					if (ferr_q == pee_pkg::ERR_NONE) ferr_q <= pee_pkg::ERR_OVER;
				end else begin
					cnt_q <= cnt_q + pee_pkg::CNT_W'(1);
				end
				if (state_q != pee_pkg::ST_PUSHRES) begin
					acc_q <= '0;
					innum_q <= 1'b0;
				end
			end
			if (state_q == pee_pkg::ST_POPA || state_q == pee_pkg::ST_POPB
					|| state_q == pee_pkg::ST_FINPOP) begin
				if (empty) begin
					if (ferr_q == pee_pkg::ERR_NONE) ferr_q <= pee_pkg::ERR_UNDER;
				end else begin
					cnt_q <= cnt_q - pee_pkg::CNT_W'(1);
				end
			end
			if (state_q == pee_pkg::ST_EXEC && rsp.done && rsp.err != pee_pkg::ERR_NONE
					&& ferr_q == pee_pkg::ERR_NONE) begin
				ferr_q <= rsp.err;
			end
			if (out_load) begin
				cnt_q <= '0;
				acc_q <= '0;
				innum_q <= 1'b0;
				ferr_q <= pee_pkg::ERR_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ch_q <= s_axis_tdata;
			last_q <= s_axis_tlast;
		end
		if (state_q == pee_pkg::ST_POPA) ua_q <= empty;
		if (state_q == pee_pkg::ST_POPB) ub_q <= empty;
		if (state_q == pee_pkg::ST_FINPOP) uf_q <= empty;
		if (pa_q) a_q <= ua_q ? 32'hFFFF_FFFF : rd_q;
		if (out_load) begin
			out_val_q <= uf_q ? 32'hFFFF_FFFF : rd_q;
			out_st_q <= ferr_q;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {5'd0, out_st_q, out_val_q};

	`PEE_ASSERT_IMP(a_busy_not_ready, clk, arst_n,
		state_q != pee_pkg::ST_IDLE, !s_axis_tready)
	`PEE_ASSERT_IMP(a_cnt_range, clk, arst_n,
		1'b1, cnt_q <= pee_pkg::CNT_W'(pee_pkg::STACK_DEPTH))
	`PEE_ASSERT_NXT(a_out_after_final, clk, arst_n,
		out_load, m_axis_tvalid && cnt_q == '0)

endmodule
